// File: sv/c6502_pkg.sv
// Shared types and constants for the 6502-subset core.
package c6502_pkg;

   // flag_bits layout: N V D I Z C, bit 5 down to bit 0
   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_I = 2;
   localparam int unsigned FLAG_D = 3;
   localparam int unsigned FLAG_V = 4;
   localparam int unsigned FLAG_N = 5;

   localparam logic OP_RESET = 1'b0;
   localparam logic OP_DONE  = 1'b1;

   // sequencer phases
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_VEC_LO = 3'd1;
   localparam logic [2:0] PH_VEC_HI = 3'd2;
   localparam logic [2:0] PH_FETCH  = 3'd3;
   localparam logic [2:0] PH_OPER1  = 3'd4;
   localparam logic [2:0] PH_OPER2  = 3'd5;
   localparam logic [2:0] PH_READ   = 3'd6;
   localparam logic [2:0] PH_STORE  = 3'd7;

   localparam logic [15:0] VEC_LO = 16'hFFFC;
   localparam logic [15:0] VEC_HI = 16'hFFFD;

   localparam logic [7:0] OPC_CLC     = 8'h18;
   localparam logic [7:0] OPC_SEC     = 8'h38;
   localparam logic [7:0] OPC_CLI     = 8'h58;
   localparam logic [7:0] OPC_SEI     = 8'h78;
   localparam logic [7:0] OPC_CLV     = 8'hB8;
   localparam logic [7:0] OPC_CLD     = 8'hD8;
   localparam logic [7:0] OPC_SED     = 8'hF8;
   localparam logic [7:0] OPC_JMP     = 8'h4C;
   localparam logic [7:0] OPC_STA     = 8'h8D;
   localparam logic [7:0] OPC_BIT_IMM = 8'h89;

   // low five opcode bits select the addressing group
   localparam logic [4:0] LOW_BRANCH = 5'h10;
   localparam logic [4:0] LOW_IMM    = 5'h09;
   localparam logic [4:0] LOW_ABS    = 5'h0D;

   // opcode rows (bits 7:5) select the ALU operation
   localparam logic [2:0] ALU_ORA = 3'd0;
   localparam logic [2:0] ALU_AND = 3'd1;
   localparam logic [2:0] ALU_EOR = 3'd2;
   localparam logic [2:0] ALU_ADC = 3'd3;
   localparam logic [2:0] ALU_LDA = 3'd5;
   localparam logic [2:0] ALU_CMP = 3'd6;
   localparam logic [2:0] ALU_SBC = 3'd7;

   // branch condition select (opcode bits 7:6)
   localparam logic [1:0] BR_N = 2'd0;
   localparam logic [1:0] BR_V = 2'd1;
   localparam logic [1:0] BR_C = 2'd2;
   localparam logic [1:0] BR_Z = 2'd3;

   typedef enum logic [2:0] {
      KIND_NONE, KIND_FLAG, KIND_BRANCH, KIND_IMM, KIND_ABS, KIND_STORE, KIND_JUMP
   } op_kind_type;

   typedef struct packed {
      logic       op;
      logic [7:0] rdata;
   } req_type;

   typedef struct packed {
      logic        bus_valid;
      logic [15:0] bus_addr;
      logic        bus_write;
      logic [7:0]  bus_wdata;
      logic        instr_done;
      logic        halted;
      logic [15:0] pc_now;
      logic [7:0]  acc_now;
      logic [7:0]  status_now;
   } rsp_type;

   // architectural and sequencing state
   typedef struct packed {
      logic [15:0] pc;
      logic [7:0]  acc;
      logic [5:0]  flags;
      logic [2:0]  phase;
      logic [7:0]  opcode;
      logic [15:0] operand;
      logic        halt;
   } cpu_state_type;

endpackage

// File: sv/c6502_alu.sv
// Binary ALU for ORA, AND, EOR, ADC, LDA, CMP and SBC.
module c6502_alu
   import c6502_pkg::*;
(
   input  logic [2:0] alu_op,
   input  logic [7:0] acc,
   input  logic [7:0] operand,
   input  logic [5:0] flags,
   output logic [7:0] acc_out,
   output logic [5:0] flags_out
);

   logic [7:0] addend;
   logic       carry_in;
   logic [8:0] sum;
   logic [7:0] result;

   // SBC and CMP add the inverted operand; CMP forces carry in
   assign addend   = (alu_op == ALU_ADC) ? operand : ~operand;
   assign carry_in = (alu_op == ALU_CMP) ? 1'b1 : flags[FLAG_C];
   assign sum      = {1'b0, acc} + {1'b0, addend} + {8'd0, carry_in};

   always_comb begin
      acc_out   = acc;
      flags_out = flags;
      result    = operand;
      case (alu_op)
         ALU_ORA: begin
            result  = acc | operand;
            acc_out = result;
         end
         ALU_AND: begin
            result  = acc & operand;
            acc_out = result;
         end
         ALU_EOR: begin
            result  = acc ^ operand;
            acc_out = result;
         end
         ALU_ADC, ALU_SBC: begin
            result            = sum[7:0];
            acc_out           = result;
            flags_out[FLAG_C] = sum[8];
            flags_out[FLAG_V] = ~(acc[7] ^ addend[7]) & (acc[7] ^ result[7]);
         end
         ALU_CMP: begin
            result            = sum[7:0];
            flags_out[FLAG_C] = sum[8];
         end
         default: begin
            // LDA
            result  = operand;
            acc_out = operand;
         end
      endcase
      flags_out[FLAG_N] = result[7];
      flags_out[FLAG_Z] = (result == 8'd0);
   end

endmodule

// File: sv/c6502_exec.sv
// Single-step sequencer: next state and bus request for one completed access.
module c6502_exec
   import c6502_pkg::*;
(
   input  cpu_state_type st,
   input  req_type       item,
   output cpu_state_type st_next,
   output rsp_type       rsp
);

   function automatic op_kind_type classify(input logic [7:0] code);
      op_kind_type k;
      case (code)
         OPC_CLC, OPC_SEC, OPC_CLI, OPC_SEI, OPC_CLV, OPC_CLD, OPC_SED: k = KIND_FLAG;
         OPC_JMP:     k = KIND_JUMP;
         OPC_STA:     k = KIND_STORE;
         OPC_BIT_IMM: k = KIND_NONE;
         default: begin
            if (code[4:0] == LOW_BRANCH)   k = KIND_BRANCH;
            else if (code[4:0] == LOW_IMM) k = KIND_IMM;
            else if (code[4:0] == LOW_ABS) k = KIND_ABS;
            else                           k = KIND_NONE;
         end
      endcase
      return k;
   endfunction

   op_kind_type fetch_kind;
   op_kind_type cur_kind;
   logic [7:0]  alu_acc;
   logic [5:0]  alu_flags;
   logic        br_flag;
   logic        br_taken;
   logic [15:0] br_offset;
   logic [15:0] pc_plus1;
   logic [15:0] pc_plus2;
   logic [15:0] pc_plus3;
   logic [15:0] operand_full;
   logic        valid;
   logic        wr;
   logic        done;
   logic [15:0] addr;

   c6502_alu u_alu (
      .alu_op    (st.opcode[7:5]),
      .acc       (st.acc),
      .operand   (item.rdata),
      .flags     (st.flags),
      .acc_out   (alu_acc),
      .flags_out (alu_flags)
   );

   assign fetch_kind   = classify(item.rdata);
   assign cur_kind     = classify(st.opcode);
   assign pc_plus1     = st.pc + 16'd1;
   assign pc_plus2     = st.pc + 16'd2;
   assign pc_plus3     = st.pc + 16'd3;
   assign br_offset    = {{8{item.rdata[7]}}, item.rdata};
   assign operand_full = {item.rdata, st.operand[7:0]};

   // opcode bits 7:6 pick N, V, C, Z; bit 5 is the value that takes the branch
   always_comb begin
      case (st.opcode[7:6])
         BR_N:    br_flag = st.flags[FLAG_N];
         BR_V:    br_flag = st.flags[FLAG_V];
         BR_C:    br_flag = st.flags[FLAG_C];
         default: br_flag = st.flags[FLAG_Z];
      endcase
      br_taken = (br_flag == st.opcode[5]);
   end

   always_comb begin
      st_next = st;
      valid   = 1'b0;
      wr      = 1'b0;
      done    = 1'b0;
      addr    = 16'd0;
      if (item.op == OP_RESET) begin
         st_next.halt  = 1'b0;
         st_next.phase = PH_VEC_LO;
         valid         = 1'b1;
         addr          = VEC_LO;
      end else if (!st.halt && st.phase != PH_IDLE) begin
         valid = 1'b1;
         case (st.phase)
            PH_VEC_LO: begin
               st_next.operand = {8'd0, item.rdata};
               st_next.phase   = PH_VEC_HI;
               addr            = VEC_HI;
            end
            PH_VEC_HI: begin
               st_next.pc    = operand_full;
               st_next.phase = PH_FETCH;
               done          = 1'b1;
               addr          = operand_full;
            end
            PH_FETCH: begin
               st_next.opcode = item.rdata;
               if (fetch_kind == KIND_NONE) begin
                  st_next.halt  = 1'b1;
                  st_next.phase = PH_IDLE;
                  valid         = 1'b0;
               end else if (fetch_kind == KIND_FLAG) begin
                  case (item.rdata)
                     OPC_CLC: st_next.flags[FLAG_C] = 1'b0;
                     OPC_SEC: st_next.flags[FLAG_C] = 1'b1;
                     OPC_CLI: st_next.flags[FLAG_I] = 1'b0;
                     OPC_SEI: st_next.flags[FLAG_I] = 1'b1;
                     OPC_CLV: st_next.flags[FLAG_V] = 1'b0;
                     OPC_CLD: st_next.flags[FLAG_D] = 1'b0;
                     default: st_next.flags[FLAG_D] = 1'b1;
                  endcase
                  st_next.pc = pc_plus1;
                  done       = 1'b1;
                  addr       = pc_plus1;
               end else begin
                  st_next.phase = PH_OPER1;
                  addr          = pc_plus1;
               end
            end
            PH_OPER1: begin
               if (cur_kind == KIND_BRANCH) begin
                  st_next.pc    = br_taken ? (pc_plus2 + br_offset) : pc_plus2;
                  st_next.phase = PH_FETCH;
                  done          = 1'b1;
                  addr          = st_next.pc;
               end else if (cur_kind == KIND_IMM) begin
                  st_next.acc   = alu_acc;
                  st_next.flags = alu_flags;
                  st_next.pc    = pc_plus2;
                  st_next.phase = PH_FETCH;
                  done          = 1'b1;
                  addr          = pc_plus2;
               end else begin
                  st_next.operand = {8'd0, item.rdata};
                  st_next.phase   = PH_OPER2;
                  addr            = pc_plus2;
               end
            end
            PH_OPER2: begin
               st_next.operand = operand_full;
               addr            = operand_full;
               if (cur_kind == KIND_JUMP) begin
                  st_next.pc    = operand_full;
                  st_next.phase = PH_FETCH;
                  done          = 1'b1;
               end else if (cur_kind == KIND_STORE) begin
                  st_next.phase = PH_STORE;
                  wr            = 1'b1;
               end else begin
                  st_next.phase = PH_READ;
               end
            end
            PH_READ: begin
               st_next.acc   = alu_acc;
               st_next.flags = alu_flags;
               st_next.pc    = pc_plus3;
               st_next.phase = PH_FETCH;
               done          = 1'b1;
               addr          = pc_plus3;
            end
            default: begin
               // store write finished
               st_next.pc    = pc_plus3;
               st_next.phase = PH_FETCH;
               done          = 1'b1;
               addr          = pc_plus3;
            end
         endcase
      end
   end

   always_comb begin
      rsp.bus_valid  = valid;
      rsp.bus_addr   = valid ? addr : 16'd0;
      rsp.bus_write  = valid & wr;
      rsp.bus_wdata  = (valid && wr) ? st_next.acc : 8'd0;
      rsp.instr_done = done;
      rsp.halted     = st_next.halt;
      rsp.pc_now     = st_next.pc;
      rsp.acc_now    = st_next.acc;
      rsp.status_now = {st_next.flags[FLAG_N], st_next.flags[FLAG_V], 2'b00,
                        st_next.flags[FLAG_D], st_next.flags[FLAG_I],
                        st_next.flags[FLAG_Z], st_next.flags[FLAG_C]};
   end

endmodule

// File: sv/cpu_6502_subset_core.sv
// 6502-subset core: one bus access completion in, next bus request out.
// A result passes through the input register, then the result register; one item
// per cycle sustained while the output is not stalled, set by the single
// sequencer/ALU step between the two registers.
// Reset (synchronous, active high) clears the CPU state and both stage valids.
module cpu_6502_subset_core
   import c6502_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   req_type       req_ff;
   logic          req_vld_ff;
   cpu_state_type state_ff;
   cpu_state_type state_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_vld_ff;
   logic          out_free;
   logic          advance;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign advance   = req_vld_ff && out_free;
   assign req_stall = req_vld_ff && !out_free;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   c6502_exec u_exec (
      .st      (state_ff),
      .item    (req_ff),
      .st_next (state_in),
      .rsp     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         if (!req_stall) begin
            req_vld_ff <= req_valid;
         end
         if (out_free) begin
            rsp_vld_ff <= req_vld_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
